>>> rtl/framed_command_ack_link_top_defines.svh
// assertion macros shared by the link rtl
`ifndef FRAMED_COMMAND_ACK_LINK_TOP_DEFINES_SVH
`define FRAMED_COMMAND_ACK_LINK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every edge outside reset
`define FCAL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked on every edge including reset
`define FCAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FCAL_ASSERT(lbl, clk, rst, prop, msg)
`define FCAL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/fcal_pkg.sv
// types and constants of the framed command and acknowledge link
`default_nettype none

package fcal_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 8;
  localparam int RX_COUNT_W  = $clog2(FRAME_BYTES);
  localparam logic [RX_COUNT_W-1:0] LAST_BYTE = RX_COUNT_W'(FRAME_BYTES - 1);

  // input opcodes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_RX_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START_MARKER  = 2'd0;
  localparam logic [1:0] CFG_END_MARKER    = 2'd1;
  localparam logic [1:0] CFG_ACK_CODE      = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

  // configuration reset values
  localparam logic [7:0]  START_MARKER_RESET  = 8'd2;
  localparam logic [7:0]  END_MARKER_RESET    = 8'd3;
  localparam logic [7:0]  ACK_CODE_RESET      = 8'd6;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd500;

  // tick counter ceiling
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  slave_id;
    logic [7:0]  command;
    logic [7:0]  pump;
    logic [15:0] time_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [7:0]  ack_code;
    logic [15:0] timeout_ticks;
  } cfg_regs_t;

  // work handed from the front to the back: a whole frame or a single report
  typedef struct packed {
    logic [1:0]                  kind;
    logic [FRAME_BYTES-1:0][7:0] frame;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/fcal_front.sv
// front end: accepts items, tracks the acknowledge wait and builds jobs
`default_nettype none

`include "framed_command_ack_link_top_defines.svh"

module fcal_front
  import fcal_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_regs_t cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      q_full,
  output logic           q_push,
  output job_t           q_data
);

  logic                  waiting;
  logic                  waiting_next;
  logic [7:0]            expected_slave;
  logic [7:0]            expected_slave_next;
  logic [7:0]            expected_command;
  logic [7:0]            expected_command_next;
  logic [RX_COUNT_W-1:0] rx_count;
  logic [RX_COUNT_W-1:0] rx_count_next;
  logic [15:0]           elapsed_ticks;
  logic [15:0]           elapsed_ticks_next;
  logic [7:0]            rx_bytes [1:FRAME_BYTES-2];

  logic                  accept;
  logic                  rx_store;
  logic [7:0]            tx_sum;
  logic [7:0]            rx_sum;
  logic                  frame_ok;
  logic [15:0]           tick_inc;

  // one item per cycle while the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // checksum of an outgoing frame body
  assign tx_sum = in_data.slave_id + in_data.command + in_data.pump
                + in_data.time_value[15:8] + in_data.time_value[7:0];

  // checks on a collected frame, closing byte arriving now
  assign rx_sum   = rx_bytes[1] + rx_bytes[2] + rx_bytes[3] + rx_bytes[4] + rx_bytes[5];
  assign frame_ok = (in_data.rx_byte == cfg.end_marker)
                 && (rx_bytes[6] == rx_sum)
                 && (rx_bytes[1] == expected_slave)
                 && (rx_bytes[2] == cfg.ack_code)
                 && (rx_bytes[3] == expected_command);

  // saturating tick count
  assign tick_inc = (elapsed_ticks == TICKS_MAX) ? elapsed_ticks : elapsed_ticks + 16'd1;

  // classify the item and work out the next wait state
  always_comb begin
    waiting_next          = waiting;
    expected_slave_next   = expected_slave;
    expected_command_next = expected_command;
    rx_count_next         = rx_count;
    elapsed_ticks_next    = elapsed_ticks;
    rx_store              = 1'b0;
    q_push                = 1'b0;
    q_data.kind           = KIND_TX;
    q_data.frame[0]       = cfg.start_marker;
    q_data.frame[1]       = in_data.slave_id;
    q_data.frame[2]       = in_data.command;
    q_data.frame[3]       = in_data.pump;
    q_data.frame[4]       = in_data.time_value[15:8];
    q_data.frame[5]       = in_data.time_value[7:0];
    q_data.frame[6]       = tx_sum;
    q_data.frame[7]       = cfg.end_marker;
    if (accept) begin
      case (in_data.opcode)
        OP_SEND: begin
          q_push                = 1'b1;
          waiting_next          = 1'b1;
          expected_slave_next   = in_data.slave_id;
          expected_command_next = in_data.command;
          rx_count_next         = '0;
          elapsed_ticks_next    = '0;
        end
        OP_RX_BYTE: begin
          if (waiting) begin
            if (rx_count == LAST_BYTE) begin
              rx_count_next = '0;
              if (frame_ok) begin
                waiting_next = 1'b0;
                q_push       = 1'b1;
                q_data.kind  = KIND_ACK;
              end
            end else if (rx_count != '0 || in_data.rx_byte == cfg.start_marker) begin
              rx_count_next = rx_count + RX_COUNT_W'(1);
              rx_store      = (rx_count != '0);
            end
          end
        end
        OP_TICK: begin
          if (waiting) begin
            elapsed_ticks_next = tick_inc;
            if (!(tick_inc < cfg.timeout_ticks)) begin
              waiting_next  = 1'b0;
              rx_count_next = '0;
              q_push        = 1'b1;
              q_data.kind   = KIND_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // wait state
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting          <= 1'b0;
      expected_slave   <= '0;
      expected_command <= '0;
      rx_count         <= '0;
      elapsed_ticks    <= '0;
    end else begin
      waiting          <= waiting_next;
      expected_slave   <= expected_slave_next;
      expected_command <= expected_command_next;
      rx_count         <= rx_count_next;
      elapsed_ticks    <= elapsed_ticks_next;
    end
  end

  // collected body bytes
  always_ff @(posedge clk) begin
    if (rx_store) begin
      rx_bytes[rx_count] <= in_data.rx_byte;
    end
  end

  `FCAL_ASSERT(a_idle_count_clear, clk, rst, !waiting |-> rx_count == '0, "collection count set while not waiting")
  `FCAL_ASSERT(a_push_has_room, clk, rst, q_push |-> !q_full, "job pushed into a full queue")

endmodule

`default_nettype wire

>>> rtl/fcal_queue.sv
// job queue between the front and back ends
`default_nettype none

`include "framed_command_ack_link_top_defines.svh"

module fcal_queue
  import fcal_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

  job_t               entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == COUNT_MAX);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `FCAL_ASSERT(a_count_bound, clk, rst, count <= COUNT_MAX, "queue fill level beyond depth")

endmodule

`default_nettype wire

>>> rtl/fcal_back.sv
// back end: plays jobs out as results through an output register
`default_nettype none

`include "framed_command_ack_link_top_defines.svh"

module fcal_back
  import fcal_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_empty,
  input  wire job_t      q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic                        busy;
  logic [RX_COUNT_W-1:0]       idx;
  logic [FRAME_BYTES-1:0][7:0] frame;
  logic                        advance;

  // output register is free or its transfer completes now
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && !busy && !q_empty;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      if (busy) begin
        out_valid <= 1'b1;
        idx       <= idx + RX_COUNT_W'(1);
        if (idx == LAST_BYTE) begin
          busy <= 1'b0;
        end
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        if (q_data.kind == KIND_TX) begin
          busy <= 1'b1;
          idx  <= RX_COUNT_W'(1);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload and frame being sent
  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        out_data.kind    <= KIND_TX;
        out_data.tx_byte <= frame[idx];
        out_data.last    <= (idx == LAST_BYTE);
      end else if (!q_empty) begin
        frame <= q_data.frame;
        if (q_data.kind == KIND_TX) begin
          out_data.kind    <= KIND_TX;
          out_data.tx_byte <= q_data.frame[0];
          out_data.last    <= 1'b0;
        end else begin
          out_data.kind    <= q_data.kind;
          out_data.tx_byte <= '0;
          out_data.last    <= 1'b1;
        end
      end
    end
  end

  `FCAL_ASSERT(a_busy_holds_byte, clk, rst, busy |-> out_valid, "frame in progress without a byte on the output")
  `FCAL_ASSERT(a_mid_frame_busy, clk, rst, (out_valid && !out_data.last) |-> busy, "non-final result outside a frame")

endmodule

`default_nettype wire

>>> rtl/framed_command_ack_link_top.sv
// Master side of a framed command link with acknowledge wait.
// Input channel (in_valid/in_ready/in_data): a send item queues one 8-byte
// frame (start, slave, command, pump, time high, time low, sum, end) and
// arms the acknowledge wait; a received byte is collected into an incoming
// frame while waiting; a tick counts one millisecond toward the timeout.
// Output channel (out_valid/out_ready/out_data): transmit bytes, then an
// acknowledge or timeout report, each with last set on an item's final result.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready.
// The first result of an item passes the job queue and the output register.
// Items are taken one per cycle while the job queue has room; results leave
// one per cycle while out_ready is high, so a send holds the output for its
// 8 bytes and the queue depth sets how many jobs can be taken ahead of it.
// When the receiver stalls the output register holds its result, the queue
// fills and in_ready drops once it is full.
// Reset clears the wait state, the queue and the output register and loads
// the configuration defaults; there is no clearing pass.
`default_nettype none

module framed_command_ack_link_top
  import fcal_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_regs_t cfg;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  job_t      q_in;
  job_t      q_out;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker  <= START_MARKER_RESET;
      cfg.end_marker    <= END_MARKER_RESET;
      cfg.ack_code      <= ACK_CODE_RESET;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_MARKER:  cfg.start_marker  <= cfg_data[7:0];
        CFG_END_MARKER:    cfg.end_marker    <= cfg_data[7:0];
        CFG_ACK_CODE:      cfg.ack_code      <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // item intake and acknowledge tracking
  fcal_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // job queue
  fcal_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // result play-out
  fcal_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
